// File: rtl/dht_pkg.sv
// Package with shared constants and types for the double hash table.
`default_nettype none
package dht_pkg;
   localparam int TableDepth = 1024;
   localparam int SlotWidth  = $clog2(TableDepth);
   localparam int SizeWidth  = SlotWidth + 1;
   localparam int KeyWidth   = 32;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      MARK_EMPTY    = 2'd0,
      MARK_OCCUPIED = 2'd1,
      MARK_DELETED  = 2'd2,
      MARK_SPARE    = 2'd3
   } mark_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;
endpackage
`default_nettype wire

// File: rtl/dht_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface dht_req_if (input wire logic clock);
   logic                              valid;
   logic                              ready;
   logic [1:0]                        mode;
   logic signed [dht_pkg::KeyWidth-1:0] key;
   modport source (output valid, mode, key, input ready);
   modport sink (input valid, mode, key, output ready);
endinterface

interface dht_rsp_if (input wire logic clock);
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [9:0]                       slot;
   modport source (output valid, status, slot, input ready);
   modport sink (input valid, status, slot, output ready);
endinterface
`default_nettype wire

// File: rtl/dht_mod.sv
// Bit-serial remainder unit: non-negative remainder of a signed key by a divisor.
`default_nettype none
module dht_mod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [dht_pkg::KeyWidth-1:0] key,
   input  wire logic [dht_pkg::SizeWidth-1:0] divisor,
   output logic                               done,
   output logic [dht_pkg::SizeWidth-1:0]      rem
);
   localparam int KW = dht_pkg::KeyWidth;
   localparam int SW = dht_pkg::SizeWidth;
   localparam int CW = $clog2(KW + 1);

   logic          busy_ff, busy_in;
   logic          fix_ff, fix_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [SW:0]   rem_ff, rem_in;
   logic [SW-1:0] div_ff, div_in;
   logic          done_ff, done_in;
   logic [SW+1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(KW);
         neg_in  = key[KW-1];
         mag_in  = key[KW-1] ? (~key + 1'b1) : key;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         trial  = {rem_ff, mag_ff[KW-1]} - {2'b00, div_ff};
         mag_in = {mag_ff[KW-2:0], 1'b0};
         if (!trial[SW+1]) rem_in = trial[SW:0];
         else              rem_in = {rem_ff[SW-1:0], mag_ff[KW-1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         if (neg_ff && rem_ff != '0) rem_in = {1'b0, div_ff} - rem_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[SW-1:0];
endmodule
`default_nettype wire

// File: rtl/double_hash_table.sv
// Top level of the double-hashing open-addressing hash set.
// Usage:
// The request channel carries one word per operation: a mode (search,
// insert, delete; the spare code acts as a search) and a signed 32-bit key.
// The response channel returns exactly one word per request, a status and
// the slot index, in request order. The csr port writes the table size,
// which is clamped into 2 .. 1024 and must only change while idle.
// Two serial remainder passes compute the home slot and the step, then
// each probe steps through an address, a synchronous memory read and a
// compare state. An insert that misses walks the probe sequence twice. The
// remainder unit and the single-port mark and key memories set the speed.
// One operation is in flight at a time; the next request is taken as soon
// as the result sits in the response register, so a waiting result does
// not hold back the next request until a second result is ready.
// Reset clears the control logic and then sweeps the mark memory to empty,
// one slot per cycle across all 1024 slots, during which no request is taken.
// If the receiver stalls, the response holds steady until it is taken.
`default_nettype none
module double_hash_table (
   input  wire logic         clock,
   input  wire logic         reset,
   dht_req_if.sink           req,
   dht_rsp_if.source         rsp,
   input  wire logic         csr_we,
   input  wire logic [10:0]  csr_wdata
);
   localparam int SW = dht_pkg::SlotWidth;
   localparam int ZW = dht_pkg::SizeWidth;
   localparam int KW = dht_pkg::KeyWidth;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_HASH0 = 11'b00000000100,
      S_HASH1 = 11'b00000001000,
      S_ADDR  = 11'b00000010000,
      S_READ  = 11'b00000100000,
      S_CHECK = 11'b00001000000,
      S_IADDR = 11'b00010000000,
      S_IREAD = 11'b00100000000,
      S_ICHK  = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [ZW-1:0] size_ff;
   logic [ZW-1:0] bmod;
   logic [1:0]    mode_ff, mode_in;
   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] h0_ff, h0_in, g0_ff, g0_in, pos_ff, pos_in;
   logic [ZW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rst_ff, rst_in;
   logic [9:0]    rslot_ff, rslot_in;
   logic [1:0]    pst_ff, pst_in;
   logic [9:0]    pslot_ff, pslot_in;
   logic [1:0]    mark_q;
   logic [KW-1:0] key_q;
   logic          mwe;
   logic [SW-1:0] maddr;
   logic [1:0]    mwdata;
   logic          kwe;
   logic          mstart;
   logic signed [KW-1:0] mkey;
   logic [ZW-1:0] mdiv;
   logic          mdone;
   logic [ZW-1:0] mrem;
   logic [ZW:0]   step_sum;

   logic [1:0]    mark_mem [dht_pkg::TableDepth];
   logic [KW-1:0] key_mem  [dht_pkg::TableDepth];

   always_comb begin
      bmod = size_ff;
      if (size_ff < ZW'(2)) bmod = ZW'(2);
      if (size_ff > ZW'(dht_pkg::TableDepth)) bmod = ZW'(dht_pkg::TableDepth);
   end

   dht_mod u_mod (
      .clock(clock), .reset(reset), .start(mstart), .key(mkey),
      .divisor(mdiv), .done(mdone), .rem(mrem)
   );

   // Next probe position: pos + g0 wrapped once by B (both are below B).
   assign step_sum = {1'b0, ZW'(pos_ff)} + {1'b0, ZW'(g0_ff)};

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      key_in   = key_ff;
      h0_in    = h0_ff;
      g0_in    = g0_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      rv_in    = rv_ff;
      rst_in   = rst_ff;
      rslot_in = rslot_ff;
      pst_in   = pst_ff;
      pslot_in = pslot_ff;
      mwe      = 1'b0;
      kwe      = 1'b0;
      maddr    = pos_ff;
      mwdata   = dht_pkg::MARK_OCCUPIED;
      mstart   = 1'b0;
      mkey     = key_ff;
      mdiv     = bmod;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mwe    = 1'b1;
            maddr  = clr_ff;
            mwdata = dht_pkg::MARK_EMPTY;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SW'(dht_pkg::TableDepth - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               mode_in  = req.mode;
               key_in   = req.key;
               mstart   = 1'b1;
               mkey     = req.key;
               state_in = S_HASH0;
            end
         end
         S_HASH0: begin
            if (mdone) begin
               h0_in    = mrem[SW-1:0];
               mstart   = 1'b1;
               mdiv     = bmod - 1'b1;
               state_in = S_HASH1;
            end
         end
         S_HASH1: begin
            if (mdone) begin
               g0_in    = SW'(bmod - 1'b1 - mrem);
               pos_in   = h0_ff;
               cnt_in   = '0;
               state_in = S_ADDR;
            end
         end
         S_ADDR, S_IADDR: begin
            state_in = (state_ff == S_ADDR) ? S_READ : S_IREAD;
         end
         S_READ:  state_in = S_CHECK;
         S_IREAD: state_in = S_ICHK;
         S_CHECK: begin
            if (mark_q == dht_pkg::MARK_OCCUPIED && key_q == key_ff) begin
               // Key found at pos.
               if (mode_ff == dht_pkg::MODE_INSERT) begin
                  pst_in   = dht_pkg::ST_DUPLICATE;
                  pslot_in = '0;
               end else begin
                  pst_in   = dht_pkg::ST_OK;
                  pslot_in = 10'(pos_ff);
                  if (mode_ff == dht_pkg::MODE_DELETE) begin
                     mwe    = 1'b1;
                     mwdata = dht_pkg::MARK_DELETED;
                  end
               end
               state_in = S_DONE;
            end else if (mark_q == dht_pkg::MARK_EMPTY ||
                         cnt_ff == bmod - 1'b1) begin
               if (mode_ff == dht_pkg::MODE_INSERT) begin
                  pos_in   = h0_ff;
                  cnt_in   = '0;
                  state_in = S_IADDR;
               end else begin
                  pst_in   = dht_pkg::ST_NOT_FOUND;
                  pslot_in = '0;
                  state_in = S_DONE;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               pos_in   = (step_sum >= {1'b0, bmod}) ? SW'(step_sum - {1'b0, bmod})
                                                     : SW'(step_sum);
               state_in = S_ADDR;
            end
         end
         S_ICHK: begin
            if (mark_q != dht_pkg::MARK_OCCUPIED) begin
               mwe      = 1'b1;
               kwe      = 1'b1;
               pst_in   = dht_pkg::ST_OK;
               pslot_in = 10'(pos_ff);
               state_in = S_DONE;
            end else if (cnt_ff == bmod - 1'b1) begin
               pst_in   = dht_pkg::ST_FULL;
               pslot_in = '0;
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               pos_in   = (step_sum >= {1'b0, bmod}) ? SW'(step_sum - {1'b0, bmod})
                                                     : SW'(step_sum);
               state_in = S_IADDR;
            end
         end
         S_DONE: begin
            // The finished result waits here until the response register is
            // free, so a stalled response word is never overwritten.
            if (!rv_ff || rsp.ready) begin
               rv_in    = 1'b1;
               rst_in   = pst_ff;
               rslot_in = pslot_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rv_ff;
   assign rsp.status = rst_ff;
   assign rsp.slot   = rslot_ff;

   always_ff @(posedge clock) begin
      if (mwe) mark_mem[maddr] <= mwdata;
      if (kwe) key_mem[maddr] <= key_ff;
      mark_q <= mark_mem[maddr];
      key_q  <= key_mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         size_ff  <= ZW'(dht_pkg::TableDepth);
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         if (csr_we) size_ff <= csr_wdata;
      end
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      h0_ff    <= h0_in;
      g0_ff    <= g0_in;
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      rst_ff   <= rst_in;
      rslot_ff <= rslot_in;
      pst_ff   <= pst_in;
      pslot_ff <= pslot_in;
   end

   a_noreq_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req.ready) else $error("request taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp.ready |=> rv_ff && $stable(rst_ff) && $stable(rslot_ff))
      else $error("response changed while stalled");
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rst_ff != dht_pkg::ST_OK |-> rslot_ff == '0)
      else $error("nonzero slot on failure");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADDR |-> ZW'(pos_ff) < bmod) else $error("probe out of range");
endmodule
`default_nettype wire
